// ----- hdl/vrpm_pkg.sv -----
package vrpm_pkg;

  localparam int AXES       = 3;
  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = 38;
  localparam int LEN_W      = 8;
  localparam int SQ_W       = 32;
  localparam int ROOT_W     = 19;
  localparam int SREM_W     = 21;
  localparam int DIV_STEPS  = SUM_W;
  localparam int SQRT_STEPS = SUM_W / 2;
  localparam int QDEPTH     = 2;

  typedef logic [1:0] axis_idx_t;
  localparam axis_idx_t FIRST_AXIS = 2'd0;
  localparam axis_idx_t LAST_AXIS  = 2'd2;

  typedef logic [5:0] step_t;
  localparam step_t DIV_LAST  = step_t'(DIV_STEPS - 1);
  localparam step_t SQRT_LAST = step_t'(SQRT_STEPS - 1);

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_OFFSET_X   = 2'd0;
  localparam reg_idx_t REG_OFFSET_Y   = 2'd1;
  localparam reg_idx_t REG_OFFSET_Z   = 2'd2;
  localparam reg_idx_t REG_WINDOW_LEN = 2'd3;

  localparam logic [LEN_W-1:0] WINDOW_LEN_RESET = 8'd30;

  typedef logic [AXES-1:0][SAMPLE_W-1:0] axis_word_t;
  typedef logic [AXES-1:0][SUM_W-1:0]    axis_sum_t;

  // One classified sample waiting for the back end
  typedef struct packed {
    axis_word_t       mag;
    axis_word_t       ptp;
    axis_sum_t        sum;
    logic [LEN_W-1:0] len;
    logic             done;
  } entry_t;

  typedef struct packed {
    axis_word_t mag;
    axis_word_t ptp;
    axis_word_t rms;
    logic       done;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CALC,
    F_ACC,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_SQRT,
    B_EMIT
  } back_state_t;

endpackage

// ----- hdl/vibration_rms_peak_monitor.sv -----
// A sample passes the front end, the two-entry queue and the back end to reach
// the output register; one that closes a window also takes a serial divide and
// root per axis there. The front end takes a new sample only once the last is
// queued, as its one squarer is shared (calc and accumulate per axis); the queue
// takes up the slack while a window end holds the back end. rst_n is synchronous, active low:
// it clears extremes, sums, count, queue and offsets, and sets window_length to 30.
module vibration_rms_peak_monitor (
  input  logic          clk,
  input  logic          rst_n,
  // Input stream
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [47:0]   in_tdata,   // sample_x, sample_y, sample_z
  // Result stream
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [143:0]  out_tdata,  // mag_x, mag_y, mag_z, ptp_x, ptp_y, ptp_z,
                                    // rms_x, rms_y, rms_z
  output logic          out_tuser,  // window_done
  // Configuration port
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [3:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready
);
  import vrpm_pkg::*;

  axis_word_t       offset_r;
  logic [LEN_W-1:0] window_len_r;
  reg_idx_t         cfg_idx;
  logic             cfg_wr;

  axis_word_t       in_samples;
  entry_t           q_wr, q_rd;
  q_status_t        q_stat;
  logic             q_push, q_pop;
  result_t          result;

  // Register file: four word-aligned registers, written on the access phase
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r     <= '0;
      window_len_r <= WINDOW_LEN_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_OFFSET_X:   offset_r[0]  <= cfg_pwdata[SAMPLE_W-1:0];
        REG_OFFSET_Y:   offset_r[1]  <= cfg_pwdata[SAMPLE_W-1:0];
        REG_OFFSET_Z:   offset_r[2]  <= cfg_pwdata[SAMPLE_W-1:0];
        REG_WINDOW_LEN: window_len_r <= cfg_pwdata[LEN_W-1:0];
        default:        ;
      endcase
    end
  end

  // Read back offsets sign-extended, the window length zero-extended
  always_comb begin
    case (cfg_idx)
      REG_OFFSET_X:   cfg_prdata = {{16{offset_r[0][SAMPLE_W-1]}}, offset_r[0]};
      REG_OFFSET_Y:   cfg_prdata = {{16{offset_r[1][SAMPLE_W-1]}}, offset_r[1]};
      REG_OFFSET_Z:   cfg_prdata = {{16{offset_r[2][SAMPLE_W-1]}}, offset_r[2]};
      REG_WINDOW_LEN: cfg_prdata = {24'd0, window_len_r};
      default:        cfg_prdata = '0;
    endcase
  end

  assign in_samples[0] = in_tdata[15:0];
  assign in_samples[1] = in_tdata[31:16];
  assign in_samples[2] = in_tdata[47:32];

  // Front end: offset correction, extremes, squares and window bookkeeping
  vrpm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_samples (in_samples),
    .offsets    (offset_r),
    .win_len    (window_len_r),
    .q_push     (q_push),
    .q_entry    (q_wr),
    .q_stat     (q_stat)
  );

  // Decouple the front end from the slow window-end arithmetic
  vrpm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (q_wr),
    .pop      (q_pop),
    .rd_entry (q_rd),
    .stat     (q_stat)
  );

  // Back end: serial divide by window length, serial square root, output register
  vrpm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_entry    (q_rd),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (result)
  );

  // Pack fields from the lowest bit up
  assign out_tdata = {result.rms[2], result.rms[1], result.rms[0],
                      result.ptp[2], result.ptp[1], result.ptp[0],
                      result.mag[2], result.mag[1], result.mag[0]};
  assign out_tuser = result.done;

endmodule

// ----- hdl/vrpm_queue.sv -----
module vrpm_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  vrpm_pkg::entry_t   wr_entry,
  input  logic               pop,
  output vrpm_pkg::entry_t   rd_entry,
  output vrpm_pkg::q_status_t stat
);
  import vrpm_pkg::*;

  entry_t     slot_r [QDEPTH];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign stat.full  = (count_r == 2'(QDEPTH));
  assign stat.empty = (count_r == 2'd0);
  assign rd_entry   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        slot_r[wr_ptr_r] <= wr_entry;
        wr_ptr_r         <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ----- hdl/vrpm_front.sv -----
module vrpm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  vrpm_pkg::axis_word_t in_samples,
  input  vrpm_pkg::axis_word_t offsets,
  input  logic [7:0]          win_len,
  output logic                q_push,
  output vrpm_pkg::entry_t    q_entry,
  input  vrpm_pkg::q_status_t q_stat
);
  import vrpm_pkg::*;

  front_state_t           state_r, state_nxt;
  axis_word_t             samp_r, min_r, max_r, mag_r, ptp_r;
  axis_sum_t              sum_r;
  logic [SQ_W-1:0]        sq_r;
  axis_idx_t              axis_r;
  logic [LEN_W-1:0]       cnt_r;

  logic [SAMPLE_W-1:0]    corr, mag, min_new, max_new;
  logic [SQ_W-1:0]        sq_val;
  logic [SUM_W-1:0]       sum_add;
  logic [LEN_W-1:0]       len_eff, cnt_inc;
  logic                   done;

  always_comb begin
    corr    = samp_r[axis_r] - offsets[axis_r];
    mag     = corr[SAMPLE_W-1] ? (SAMPLE_W'(0) - corr) : corr;
    min_new = ($signed(corr) < $signed(min_r[axis_r])) ? corr : min_r[axis_r];
    max_new = ($signed(corr) > $signed(max_r[axis_r])) ? corr : max_r[axis_r];
    sq_val  = mag * mag;
    sum_add = sum_r[axis_r] + {{(SUM_W-SQ_W){1'b0}}, sq_r};
    len_eff = (win_len == '0) ? LEN_W'(1) : win_len;
    cnt_inc = cnt_r + LEN_W'(1);
    done    = (cnt_inc >= len_eff);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE:  if (in_tvalid) state_nxt = F_CALC;
      F_CALC:  state_nxt = F_ACC;
      F_ACC:   state_nxt = (axis_r == LAST_AXIS) ? F_PUSH : F_CALC;
      F_PUSH:  if (!q_stat.full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_tready    = (state_r == F_IDLE);
    q_push       = (state_r == F_PUSH) && !q_stat.full;
    q_entry.mag  = mag_r;
    q_entry.ptp  = ptp_r;
    q_entry.sum  = sum_r;
    q_entry.len  = len_eff;
    q_entry.done = done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      min_r   <= '0;
      max_r   <= '0;
      sum_r   <= '0;
      cnt_r   <= '0;
      axis_r  <= FIRST_AXIS;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        F_IDLE: begin
          if (in_tvalid) begin
            samp_r <= in_samples;
            axis_r <= FIRST_AXIS;
          end
        end
        F_CALC: begin
          min_r[axis_r] <= min_new;
          max_r[axis_r] <= max_new;
          mag_r[axis_r] <= mag;
          ptp_r[axis_r] <= max_new - min_new;
          sq_r          <= sq_val;
        end
        F_ACC: begin
          sum_r[axis_r] <= sum_add;
          axis_r        <= (axis_r == LAST_AXIS) ? FIRST_AXIS : axis_r + 2'd1;
        end
        F_PUSH: begin
          // Close the window once the entry holding the sums is queued
          if (q_push) begin
            cnt_r <= done ? '0 : cnt_inc;
            if (done) sum_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- hdl/vrpm_back.sv -----
module vrpm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  vrpm_pkg::entry_t    q_entry,
  input  vrpm_pkg::q_status_t q_stat,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output vrpm_pkg::result_t   out_result
);
  import vrpm_pkg::*;

  back_state_t          state_r, state_nxt;
  entry_t               ent_r;
  axis_word_t           rms_r;
  axis_idx_t            axis_r;
  step_t                step_r;
  logic [SUM_W-1:0]     dq_r, sv_r;
  logic [LEN_W-1:0]     rem_r;
  logic [SREM_W-1:0]    srem_r;
  logic [ROOT_W-1:0]    root_r;
  logic                 out_valid_r;
  result_t              out_r;

  logic                 out_free, load_out;
  logic [LEN_W:0]       div_sh;
  logic                 div_ge;
  logic [LEN_W-1:0]     rem_nxt;
  logic [SUM_W-1:0]     dq_nxt;
  logic [SREM_W+1:0]    sq_sh, sq_trial;
  logic                 sq_ge;
  logic [SREM_W-1:0]    srem_nxt;
  logic [ROOT_W-1:0]    root_nxt;

  // One restoring divide step and one square-root digit step
  always_comb begin
    div_sh   = {rem_r, dq_r[SUM_W-1]};
    div_ge   = (div_sh >= {1'b0, ent_r.len});
    rem_nxt  = div_ge ? LEN_W'(div_sh - {1'b0, ent_r.len}) : LEN_W'(div_sh);
    dq_nxt   = {dq_r[SUM_W-2:0], div_ge};
    sq_sh    = {srem_r, sv_r[SUM_W-1:SUM_W-2]};
    sq_trial = {{(SREM_W-ROOT_W){1'b0}}, root_r, 2'b01};
    sq_ge    = (sq_sh >= sq_trial);
    srem_nxt = sq_ge ? SREM_W'(sq_sh - sq_trial) : SREM_W'(sq_sh);
    root_nxt = {root_r[ROOT_W-2:0], sq_ge};
  end

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:  if (!q_stat.empty) state_nxt = q_entry.done ? B_DIV : B_EMIT;
      B_DIV:   if (step_r == DIV_LAST) state_nxt = B_SQRT;
      B_SQRT:  if (step_r == SQRT_LAST) state_nxt = (axis_r == LAST_AXIS) ? B_EMIT : B_DIV;
      B_EMIT:  if (out_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = (state_r == B_IDLE) && !q_stat.empty;
    load_out = (state_r == B_EMIT) && out_free;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      axis_r      <= FIRST_AXIS;
      step_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
        out_r.mag   <= ent_r.mag;
        out_r.ptp   <= ent_r.ptp;
        out_r.rms   <= rms_r;
        out_r.done  <= ent_r.done;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (q_pop) begin
            ent_r  <= q_entry;
            rms_r  <= '0;
            axis_r <= FIRST_AXIS;
            step_r <= '0;
            dq_r   <= q_entry.sum[FIRST_AXIS];
            rem_r  <= '0;
          end
        end
        B_DIV: begin
          dq_r  <= dq_nxt;
          rem_r <= rem_nxt;
          if (step_r == DIV_LAST) begin
            sv_r   <= dq_nxt;
            srem_r <= '0;
            root_r <= '0;
            step_r <= '0;
          end else begin
            step_r <= step_r + step_t'(1);
          end
        end
        B_SQRT: begin
          sv_r   <= {sv_r[SUM_W-3:0], 2'b00};
          srem_r <= srem_nxt;
          root_r <= root_nxt;
          if (step_r == SQRT_LAST) begin
            rms_r[axis_r] <= root_nxt[SAMPLE_W-1:0];
            step_r        <= '0;
            if (axis_r != LAST_AXIS) begin
              axis_r <= axis_r + 2'd1;
              dq_r   <= ent_r.sum[axis_r + 2'd1];
              rem_r  <= '0;
            end
          end else begin
            step_r <= step_r + step_t'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule
